>>> sv/nkps_pkg.sv
package nkps_pkg;

  // Field widths fixed by the item formats.
  localparam int CMD_W     = 2;
  localparam int COORD_W   = 16;
  localparam int COLOR_W   = 16;
  localparam int DIST_W    = 34;
  localparam int CFG_IDX_W = 2;
  // Slot numbers are at most fifteen, so four bits always hold one.
  localparam int IDX_W     = 4;

  // Commands carried by an input item.
  localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd1;
  localparam logic [CMD_W-1:0] CMD_EMIT   = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y = 2'd1;

  // Operations broadcast to every cell of the chain.
  typedef logic [2:0] cell_op_t;
  localparam cell_op_t OP_HOLD  = 3'd0;
  localparam cell_op_t OP_CLEAR = 3'd1;
  localparam cell_op_t OP_INS   = 3'd2;
  localparam cell_op_t OP_DEL   = 3'd3;
  localparam cell_op_t OP_ROT   = 3'd4;

  // One kept entry, including the slot number it occupies.
  typedef struct packed {
    logic               valid;
    logic [DIST_W-1:0]  dist_sq;
    logic [IDX_W-1:0]   slot;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [COLOR_W-1:0] color;
  } entry_t;

endpackage

>>> sv/nkps_ifs.sv
// Input item channel.
interface nkps_in_if;
  logic                                valid;
  logic                                ready;
  logic [nkps_pkg::CMD_W-1:0]          command;
  logic signed [nkps_pkg::COORD_W-1:0] pos_x;
  logic signed [nkps_pkg::COORD_W-1:0] pos_y;
  logic [nkps_pkg::COLOR_W-1:0]        color;

  modport source (output valid, command, pos_x, pos_y, color, input ready);
  modport sink   (input valid, command, pos_x, pos_y, color, output ready);
endinterface

// Result item channel.
interface nkps_out_if;
  logic                                valid;
  logic                                ready;
  logic                                entry_valid;
  logic signed [nkps_pkg::COORD_W-1:0] out_x;
  logic signed [nkps_pkg::COORD_W-1:0] out_y;
  logic [nkps_pkg::COLOR_W-1:0]        out_color;
  logic [nkps_pkg::DIST_W-1:0]         distance_sq;
  logic                                last;

  modport source (output valid, entry_valid, out_x, out_y, out_color, distance_sq, last,
                  input ready);
  modport sink   (input valid, entry_valid, out_x, out_y, out_color, distance_sq, last,
                  output ready);
endinterface

// Configuration write channel.
interface nkps_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [nkps_pkg::CFG_IDX_W-1:0] index;
  logic [nkps_pkg::COORD_W-1:0]   data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

>>> sv/nearest_k_point_selector.sv
// Channel   Direction  Handshake      Payload
// in_chan   input      valid/ready    command, pos_x, pos_y, color
// out_chan  output     valid/ready    entry_valid, out_x, out_y, out_color, distance_sq, last
// cfg_chan  input      valid/ready    index, data (center_x, center_y)
//
// A clear item acts in the cycle it is accepted. An insert item steps through accept,
// square, sum, decide (removing the farthest entry when the table is full and the new
// point is strictly nearer) and insertion; a point that a full table drops ends at decide.
// An emit item rotates the cell chain SLOTS times and gives one result per kept entry
// (one empty result if none); a result step waits while the output register is still full.
// Reset is synchronous and empties the table; center registers reset to zero.
// A new item is accepted whenever the sequencer is idle, even while a result waits.
module nearest_k_point_selector #(
  parameter int SLOTS = 5
) (
  input  logic            clk,
  input  logic            rst_n,
  nkps_in_if.sink         in_chan,
  nkps_out_if.source      out_chan,
  nkps_cfg_if.sink        cfg_chan
);

  localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int NXT    = (SLOTS > 1) ? 1 : 0;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SQ   = 3'd1;
  localparam logic [2:0] S_SUM  = 3'd2;
  localparam logic [2:0] S_DEC  = 3'd3;
  localparam logic [2:0] S_INS  = 3'd4;
  localparam logic [2:0] S_EMIT = 3'd5;

  logic [2:0]                         state_r, state_nxt;
  logic [nkps_pkg::COORD_W-1:0]       cx_r, cy_r;
  logic signed [nkps_pkg::COORD_W:0]  dx_r, dy_r, dx_nxt, dy_nxt;
  logic signed [nkps_pkg::DIST_W-1:0] sqx_s, sqy_s;
  logic [nkps_pkg::DIST_W-1:0]        sqx_r, sqy_r, dist_r;
  logic [nkps_pkg::COORD_W-1:0]       px_r, py_r;
  logic [nkps_pkg::COLOR_W-1:0]       pc_r;
  logic [SLOTS-1:0]                   used_r, used_nxt;
  logic [SLOT_W-1:0]                  cnt_r, cnt_nxt;
  nkps_pkg::cell_op_t                 op;
  nkps_pkg::entry_t                   new_ent, tail_ent;
  nkps_pkg::entry_t                   ent_a [SLOTS];
  logic                               lt_a [SLOTS];
  logic                               eq_a [SLOTS];
  logic [SLOTS-1:0]                   vld_vec;
  logic [nkps_pkg::IDX_W-1:0]         free_idx, vict_slot;
  logic                               in_acc, full, step_en, emit_item, prev_eq;
  logic                               out_free;
  logic                               out_vld_r, out_ent_r, out_last_r;
  logic [nkps_pkg::COORD_W-1:0]       out_x_r, out_y_r;
  logic [nkps_pkg::COLOR_W-1:0]       out_c_r;
  logic [nkps_pkg::DIST_W-1:0]        out_d_r;

  assign in_acc        = in_chan.valid && in_chan.ready;
  assign in_chan.ready = (state_r == S_IDLE);
  assign cfg_chan.ready = 1'b1;
  assign out_free      = !out_vld_r || out_chan.ready;

  // Center registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cx_r <= '0;
      cy_r <= '0;
    end else if (cfg_chan.valid) begin
      if (cfg_chan.index == nkps_pkg::REG_CENTER_X) begin
        cx_r <= cfg_chan.data;
      end
      if (cfg_chan.index == nkps_pkg::REG_CENTER_Y) begin
        cy_r <= cfg_chan.data;
      end
    end
  end

  // Distance datapath: difference, square, sum, one register per step.
  assign dx_nxt = {in_chan.pos_x[nkps_pkg::COORD_W-1], in_chan.pos_x} -
                  {cx_r[nkps_pkg::COORD_W-1], cx_r};
  assign dy_nxt = {in_chan.pos_y[nkps_pkg::COORD_W-1], in_chan.pos_y} -
                  {cy_r[nkps_pkg::COORD_W-1], cy_r};
  assign sqx_s  = dx_r * dx_r;
  assign sqy_s  = dy_r * dy_r;

  always_ff @(posedge clk) begin
    if (in_acc) begin
      dx_r <= dx_nxt;
      dy_r <= dy_nxt;
      px_r <= in_chan.pos_x;
      py_r <= in_chan.pos_y;
      pc_r <= in_chan.color;
    end
    sqx_r  <= $unsigned(sqx_s);
    sqy_r  <= $unsigned(sqy_s);
    if (state_r == S_SUM) begin
      dist_r <= sqx_r + sqy_r;
    end
  end

  // Lowest free slot number.
  always_comb begin
    free_idx = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (!used_r[i]) begin
        free_idx = nkps_pkg::IDX_W'(i);
      end
    end
  end

  // Entry offered to the chain on insertion.
  always_comb begin
    new_ent.valid   = 1'b1;
    new_ent.dist_sq = dist_r;
    new_ent.slot    = free_idx;
    new_ent.x       = px_r;
    new_ent.y       = py_r;
    new_ent.color   = pc_r;
  end

  // Slot of the first entry at the largest distance, and the valid vector.
  always_comb begin
    vict_slot = '0;
    prev_eq   = 1'b0;
    for (int i = 0; i < SLOTS; i++) begin
      if (eq_a[i] && !prev_eq) begin
        vict_slot = vict_slot | ent_a[i].slot;
      end
      prev_eq    = eq_a[i];
      vld_vec[i] = ent_a[i].valid;
    end
  end

  assign full = ent_a[SLOTS-1].valid;

  // The last cell takes the head back during rotation, else an empty entry.
  always_comb begin
    tail_ent       = '0;
    if (op == nkps_pkg::OP_ROT) begin
      tail_ent = ent_a[0];
    end
  end

  // The chain of cells.
  for (genvar g = 0; g < SLOTS; g++) begin : g_cell
    if (g == 0) begin : g_head
      nkps_cell u_cell (
        .clk       (clk),
        .rst_n     (rst_n),
        .op        (op),
        .new_ent   (new_ent),
        .left_ent  (new_ent),
        .left_lt   (1'b0),
        .right_ent ((SLOTS > 1) ? ent_a[NXT] : tail_ent),
        .last_dist (ent_a[SLOTS-1].dist_sq),
        .ent       (ent_a[g]),
        .lt        (lt_a[g]),
        .eq        (eq_a[g])
      );
    end else begin : g_body
      nkps_cell u_cell (
        .clk       (clk),
        .rst_n     (rst_n),
        .op        (op),
        .new_ent   (new_ent),
        .left_ent  (ent_a[g-1]),
        .left_lt   (lt_a[g-1]),
        .right_ent ((g == SLOTS - 1) ? tail_ent : ent_a[(g == SLOTS - 1) ? g : g + 1]),
        .last_dist (ent_a[SLOTS-1].dist_sq),
        .ent       (ent_a[g]),
        .lt        (lt_a[g]),
        .eq        (eq_a[g])
      );
    end
  end

  // Emit stepping: a step that gives a result needs a free output register.
  assign emit_item = ent_a[0].valid || (cnt_r == '0);
  assign step_en   = out_free || !emit_item;

  // Sequencer.
  always_comb begin
    state_nxt = state_r;
    used_nxt  = used_r;
    cnt_nxt   = cnt_r;
    op        = nkps_pkg::OP_HOLD;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (in_chan.command == nkps_pkg::CMD_CLEAR) begin
            op       = nkps_pkg::OP_CLEAR;
            used_nxt = '0;
          end else if (in_chan.command == nkps_pkg::CMD_INSERT) begin
            state_nxt = S_SQ;
          end else if (in_chan.command == nkps_pkg::CMD_EMIT) begin
            cnt_nxt   = '0;
            state_nxt = S_EMIT;
          end
        end
      end
      S_SQ: begin
        state_nxt = S_SUM;
      end
      S_SUM: begin
        state_nxt = S_DEC;
      end
      S_DEC: begin
        if (!full) begin
          state_nxt = S_INS;
        end else if (dist_r < ent_a[SLOTS-1].dist_sq) begin
          op                          = nkps_pkg::OP_DEL;
          used_nxt[vict_slot[SLOT_W-1:0]] = 1'b0;
          state_nxt                   = S_INS;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_INS: begin
        op                             = nkps_pkg::OP_INS;
        used_nxt[free_idx[SLOT_W-1:0]] = 1'b1;
        state_nxt                      = S_IDLE;
      end
      S_EMIT: begin
        if (step_en) begin
          op = nkps_pkg::OP_ROT;
          if (cnt_r == SLOT_W'(SLOTS - 1)) begin
            state_nxt = S_IDLE;
          end else begin
            cnt_nxt = cnt_r + 1'b1;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      used_r  <= '0;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      used_r  <= used_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if ((state_r == S_EMIT) && step_en && emit_item) begin
      out_vld_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state_r == S_EMIT) && step_en && emit_item) begin
      out_ent_r  <= ent_a[0].valid;
      out_x_r    <= ent_a[0].valid ? ent_a[0].x : '0;
      out_y_r    <= ent_a[0].valid ? ent_a[0].y : '0;
      out_c_r    <= ent_a[0].valid ? ent_a[0].color : '0;
      out_d_r    <= ent_a[0].valid ? ent_a[0].dist_sq : '0;
      out_last_r <= !ent_a[0].valid || (cnt_r == SLOT_W'(SLOTS - 1)) || !ent_a[NXT].valid;
    end
  end

  assign out_chan.valid       = out_vld_r;
  assign out_chan.entry_valid = out_ent_r;
  assign out_chan.out_x       = out_x_r;
  assign out_chan.out_y       = out_y_r;
  assign out_chan.out_color   = out_c_r;
  assign out_chan.distance_sq = out_d_r;
  assign out_chan.last        = out_last_r;

  // An empty-table result always closes its run.
  a_empty_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && !out_ent_r |-> out_last_r)
    else $error("empty result without last flag");

  // While idle, slot bookkeeping agrees with the number of kept entries.
  a_used_count: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_IDLE |-> $countones(used_r) == $countones(vld_vec))
    else $error("slot usage mask out of step with cell chain");

  // Outside a rotation the valid entries sit packed at the head of the chain.
  a_packed: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != S_EMIT |-> (vld_vec & (vld_vec + 1'b1)) == '0)
    else $error("cell chain has a gap");

endmodule

>>> sv/nkps_cell.sv
// One cell of the sorted chain. The chain is kept ordered by distance and
// then by slot number, with the valid entries packed at the low end.
module nkps_cell (
  input  logic                          clk,
  input  logic                          rst_n,
  input  nkps_pkg::cell_op_t            op,
  input  nkps_pkg::entry_t              new_ent,
  input  nkps_pkg::entry_t              left_ent,
  input  logic                          left_lt,
  input  nkps_pkg::entry_t              right_ent,
  input  logic [nkps_pkg::DIST_W-1:0]   last_dist,
  output nkps_pkg::entry_t              ent,
  output logic                          lt,
  output logic                          eq
);

  nkps_pkg::entry_t ent_r;
  nkps_pkg::entry_t ent_nxt;

  // The new entry sorts before this one (an empty cell sorts last).
  assign lt = !ent_r.valid || (new_ent.dist_sq < ent_r.dist_sq) ||
              ((new_ent.dist_sq == ent_r.dist_sq) && (new_ent.slot < ent_r.slot));

  // This cell shares the distance of the last cell, the largest kept one when full.
  assign eq = ent_r.valid && (ent_r.dist_sq == last_dist);

  assign ent = ent_r;

  // Next content from the broadcast operation and the neighbors.
  always_comb begin
    ent_nxt = ent_r;
    case (op)
      nkps_pkg::OP_CLEAR: begin
        ent_nxt.valid = 1'b0;
      end
      nkps_pkg::OP_INS: begin
        if (lt) begin
          ent_nxt = left_lt ? left_ent : new_ent;
        end
      end
      nkps_pkg::OP_DEL: begin
        if (eq) begin
          ent_nxt = right_ent;
        end
      end
      nkps_pkg::OP_ROT: begin
        ent_nxt = right_ent;
      end
      default: begin
        ent_nxt = ent_r;
      end
    endcase
  end

  // Only the valid bit is cleared by reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ent_r.valid <= 1'b0;
    end else begin
      ent_r <= ent_nxt;
    end
  end

endmodule

>>> test/nearest_k_point_selector_checker.sv
module nearest_k_point_selector_checker #(
  parameter int SLOTS = 5
) (
  input  logic        clk,
  input  logic        rst_n,
  nkps_in_if          in_chan,
  nkps_out_if         out_chan,
  nkps_cfg_if         cfg_chan,
  output int unsigned mismatch_count,
  output int unsigned results_pending,
  output int unsigned results_checked
);
  timeunit 1ns;
  timeprecision 1ps;

  // One predicted result item.
  typedef struct packed {
    logic                         entry_valid;
    logic [nkps_pkg::COORD_W-1:0] x;
    logic [nkps_pkg::COORD_W-1:0] y;
    logic [nkps_pkg::COLOR_W-1:0] color;
    logic [nkps_pkg::DIST_W-1:0]  dist_sq;
    logic                         last;
  } kept_point_t;

  // Shadow copy of the center registers and the kept-point table.
  logic signed [nkps_pkg::COORD_W-1:0] center_x;
  logic signed [nkps_pkg::COORD_W-1:0] center_y;
  logic                                slot_valid [SLOTS];
  logic [nkps_pkg::DIST_W-1:0]         slot_dist  [SLOTS];
  logic [nkps_pkg::COORD_W-1:0]        slot_x     [SLOTS];
  logic [nkps_pkg::COORD_W-1:0]        slot_y     [SLOTS];
  logic [nkps_pkg::COLOR_W-1:0]        slot_color [SLOTS];

  kept_point_t expected_points [$];

  // Exact squared distance from the current center; 64-bit math cannot overflow.
  function automatic logic [nkps_pkg::DIST_W-1:0] squared_span(
      logic signed [nkps_pkg::COORD_W-1:0] px, logic signed [nkps_pkg::COORD_W-1:0] py);
    longint dx;
    longint dy;
    longint total;
    dx = longint'(px) - longint'(center_x);
    dy = longint'(py) - longint'(center_y);
    total = dx * dx + dy * dy;
    return total[nkps_pkg::DIST_W-1:0];
  endfunction

  task automatic keep_point(int slot, logic [nkps_pkg::DIST_W-1:0] span_sq,
                            logic [nkps_pkg::COORD_W-1:0] px,
                            logic [nkps_pkg::COORD_W-1:0] py,
                            logic [nkps_pkg::COLOR_W-1:0] pcolor);
    slot_valid[slot] = 1'b1;
    slot_dist[slot]  = span_sq;
    slot_x[slot]     = px;
    slot_y[slot]     = py;
    slot_color[slot] = pcolor;
  endtask

  // A point takes the first free slot; on a full table it displaces the
  // farthest entry (lowest slot among ties) only when strictly nearer.
  task automatic offer_point(logic signed [nkps_pkg::COORD_W-1:0] px,
                             logic signed [nkps_pkg::COORD_W-1:0] py,
                             logic [nkps_pkg::COLOR_W-1:0] pcolor);
    logic [nkps_pkg::DIST_W-1:0] span_sq;
    int                          far;
    span_sq = squared_span(px, py);
    for (int i = 0; i < SLOTS; i++) begin
      if (!slot_valid[i]) begin
        keep_point(i, span_sq, px, py, pcolor);
        return;
      end
    end
    far = 0;
    for (int i = 1; i < SLOTS; i++) begin
      if (slot_dist[i] > slot_dist[far]) far = i;
    end
    if (span_sq < slot_dist[far]) keep_point(far, span_sq, px, py, pcolor);
  endtask

  // Kept entries nearest first, equal distances in slot order; an empty
  // table yields a single all-zero item flagged as last.
  task automatic list_kept_points();
    int          order [SLOTS];
    int          n;
    int          j;
    kept_point_t pt;
    n = 0;
    for (int i = 0; i < SLOTS; i++) begin
      if (slot_valid[i]) begin
        j = n;
        while (j > 0 && slot_dist[order[j-1]] > slot_dist[i]) begin
          order[j] = order[j-1];
          j--;
        end
        order[j] = i;
        n++;
      end
    end
    if (n == 0) begin
      pt = '0;
      pt.last = 1'b1;
      expected_points.push_back(pt);
      return;
    end
    for (int k = 0; k < n; k++) begin
      pt.entry_valid = 1'b1;
      pt.x           = slot_x[order[k]];
      pt.y           = slot_y[order[k]];
      pt.color       = slot_color[order[k]];
      pt.dist_sq     = slot_dist[order[k]];
      pt.last        = (k == n - 1);
      expected_points.push_back(pt);
    end
  endtask

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("ERROR at %0t: result %0d, %s is %0h, expected %0h",
             $realtime, results_checked, what, got, want);
    mismatch_count++;
  endtask

  // Compare one accepted result item with the oldest prediction.
  task automatic compare_result();
    kept_point_t want;
    if (expected_points.size() == 0) begin
      report_mismatch("unexpected item, distance_sq", {30'b0, out_chan.distance_sq}, 64'd0);
      return;
    end
    want = expected_points.pop_front();
    results_checked++;
    if (out_chan.entry_valid !== want.entry_valid)
      report_mismatch("entry_valid", {63'b0, out_chan.entry_valid}, {63'b0, want.entry_valid});
    if (out_chan.out_x !== want.x)
      report_mismatch("out_x", {48'b0, out_chan.out_x}, {48'b0, want.x});
    if (out_chan.out_y !== want.y)
      report_mismatch("out_y", {48'b0, out_chan.out_y}, {48'b0, want.y});
    if (out_chan.out_color !== want.color)
      report_mismatch("out_color", {48'b0, out_chan.out_color}, {48'b0, want.color});
    if (out_chan.distance_sq !== want.dist_sq)
      report_mismatch("distance_sq", {30'b0, out_chan.distance_sq}, {30'b0, want.dist_sq});
    if (out_chan.last !== want.last)
      report_mismatch("last", {63'b0, out_chan.last}, {63'b0, want.last});
  endtask

  // Watch all three channels at each rising edge.
  always @(posedge clk) begin
    if (!rst_n) begin
      center_x = '0;
      center_y = '0;
      for (int i = 0; i < SLOTS; i++) slot_valid[i] = 1'b0;
      expected_points.delete();
    end else begin
      if (cfg_chan.valid && cfg_chan.ready) begin
        case (cfg_chan.index)
          nkps_pkg::REG_CENTER_X: center_x = cfg_chan.data;
          nkps_pkg::REG_CENTER_Y: center_y = cfg_chan.data;
          default: ;
        endcase
      end
      if (out_chan.valid && out_chan.ready) compare_result();
      if (in_chan.valid && in_chan.ready) begin
        case (in_chan.command)
          nkps_pkg::CMD_CLEAR:  for (int i = 0; i < SLOTS; i++) slot_valid[i] = 1'b0;
          nkps_pkg::CMD_INSERT: offer_point(in_chan.pos_x, in_chan.pos_y, in_chan.color);
          nkps_pkg::CMD_EMIT:   list_kept_points();
          default: ;
        endcase
      end
    end
    results_pending <= expected_points.size();
  end

endmodule

>>> test/nearest_k_point_selector_tb.sv
module nearest_k_point_selector_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SLOTS       = 5;
  localparam int ITEM_TARGET = 450;
  // Inserts produce no result item, so results_pending cannot show one in flight.
  localparam int HOLD_OFF    = 12;
  localparam int IDLE_LIMIT  = 5000;

  // Command and register codes the block must ignore.
  localparam logic [nkps_pkg::CMD_W-1:0]     CMD_UNUSED   = 2'd3;
  localparam logic [nkps_pkg::CFG_IDX_W-1:0] REG_SPARE_LO = 2'd2;
  localparam logic [nkps_pkg::CFG_IDX_W-1:0] REG_SPARE_HI = 2'd3;

  typedef enum logic [1:0] {RX_OPEN, RX_RANDOM, RX_PERIODIC, RX_STALLS} rx_mode_t;

  logic clk;
  logic rst_n;

  nkps_in_if  in_chan ();
  nkps_out_if out_chan ();
  nkps_cfg_if cfg_chan ();

  int unsigned mismatch_count;
  int unsigned results_pending;
  int unsigned results_checked;

  int unsigned items_sent;
  int unsigned n_clear;
  int unsigned n_insert;
  int unsigned n_emit;
  int unsigned n_ignored;
  int unsigned n_cfg;

  logic signed [nkps_pkg::COORD_W-1:0] cur_cx;
  logic signed [nkps_pkg::COORD_W-1:0] cur_cy;

  int  burst_left = 0;
  bit  steady_run = 1'b0;

  nearest_k_point_selector #(
    .SLOTS(SLOTS)
  ) i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .cfg_chan (cfg_chan)
  );

  nearest_k_point_selector_checker #(
    .SLOTS(SLOTS)
  ) i_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_chan         (in_chan),
    .out_chan        (out_chan),
    .cfg_chan        (cfg_chan),
    .mismatch_count  (mismatch_count),
    .results_pending (results_pending),
    .results_checked (results_checked)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Result receiver: switches at random between stall patterns.
  rx_mode_t rx_mode    = RX_OPEN;
  int       rx_tick    = 0;
  int       stall_left = 0;

  always @(posedge clk) begin
    rx_tick++;
    if (rx_tick % 300 == 0) rx_mode = rx_mode_t'($urandom_range(0, 3));
    if (!rst_n) begin
      out_chan.ready <= 1'b0;
    end else begin
      case (rx_mode)
        RX_OPEN:     out_chan.ready <= 1'b1;
        RX_RANDOM:   out_chan.ready <= ($urandom_range(0, 3) != 0);
        RX_PERIODIC: out_chan.ready <= (rx_tick % 7 >= 3);
        default: begin
          if (stall_left > 0) begin
            stall_left--;
            out_chan.ready <= 1'b0;
          end else if ($urandom_range(0, 9) == 0) begin
            stall_left = $urandom_range(1, 12);
            out_chan.ready <= 1'b0;
          end else begin
            out_chan.ready <= 1'b1;
          end
        end
      endcase
    end
  end

  // Watchdog: ends the run when no channel has moved an item for too long.
  wire progress = (in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready) ||
                  (cfg_chan.valid && cfg_chan.ready);
  int idle_run = 0;

  always @(posedge clk) begin
    if (!rst_n || progress) idle_run <= 0;
    else idle_run <= idle_run + 1;
    if (idle_run >= IDLE_LIMIT) begin
      $display("Timeout: no handshake for %0d cycles", IDLE_LIMIT);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Sender pacing: bursts of random length, separated by random gaps unless
  // the current scene runs without gaps.
  task automatic pace_sender();
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      if (!steady_run) begin
        in_chan.valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
    end
    burst_left--;
  endtask

  // Coordinates and color arrive as integers and keep their low 16 bits.
  task automatic offer_item(logic [nkps_pkg::CMD_W-1:0] cmd, int px, int py, int pcolor);
    pace_sender();
    in_chan.valid   <= 1'b1;
    in_chan.command <= cmd;
    in_chan.pos_x   <= 16'(px);
    in_chan.pos_y   <= 16'(py);
    in_chan.color   <= 16'(pcolor);
    do @(posedge clk); while (!in_chan.ready);
    case (cmd)
      nkps_pkg::CMD_CLEAR:  n_clear++;
      nkps_pkg::CMD_INSERT: n_insert++;
      nkps_pkg::CMD_EMIT:   n_emit++;
      default:              n_ignored++;
    endcase
    if (cmd != CMD_UNUSED) items_sent++;
  endtask

  // Hold the sender until every predicted result has arrived and any insert
  // still in flight has had time to finish.
  task automatic settle_block();
    in_chan.valid <= 1'b0;
    do @(posedge clk); while (results_pending != 0);
    repeat (HOLD_OFF) @(posedge clk);
  endtask

  task automatic write_cfg(logic [nkps_pkg::CFG_IDX_W-1:0] idx,
                           logic [nkps_pkg::COORD_W-1:0] value);
    cfg_chan.valid <= 1'b1;
    cfg_chan.index <= idx;
    cfg_chan.data  <= value;
    do @(posedge clk); while (!cfg_chan.ready);
    n_cfg++;
  endtask

  // Move the center while the block is idle; optionally also hit the spare indexes.
  task automatic set_center(logic [nkps_pkg::COORD_W-1:0] cx,
                            logic [nkps_pkg::COORD_W-1:0] cy, bit with_spare);
    settle_block();
    write_cfg(nkps_pkg::REG_CENTER_X, cx);
    if (with_spare) write_cfg(REG_SPARE_LO, 16'($urandom));
    write_cfg(nkps_pkg::REG_CENTER_Y, cy);
    if (with_spare) write_cfg(REG_SPARE_HI, 16'($urandom));
    cfg_chan.valid <= 1'b0;
    cur_cx = cx;
    cur_cy = cy;
  endtask

  function automatic logic [nkps_pkg::COORD_W-1:0] pick_extreme();
    case ($urandom_range(0, 3))
      0:       return 16'h8000;
      1:       return 16'h7FFF;
      2:       return 16'h0000;
      default: return 16'hFFFF;
    endcase
  endfunction

  function automatic logic [nkps_pkg::COORD_W-1:0] pick_center();
    if ($urandom_range(0, 2) == 0) return pick_extreme();
    return 16'($urandom);
  endfunction

  // Mostly points clustered around the center so that ties and displacements
  // are frequent, plus scattered, full-range and extreme coordinates.
  function automatic logic [nkps_pkg::COORD_W-1:0] pick_coord(
      logic [nkps_pkg::COORD_W-1:0] c);
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 5) return c + 16'($urandom_range(0, 16)) - 16'd8;
    if (sel < 7) return c + 16'($urandom_range(0, 512)) - 16'd256;
    if (sel < 9) return 16'($urandom);
    return pick_extreme();
  endfunction

  task automatic run_directed();
    // Empty table, then fill it with zero, extreme and tied distances.
    offer_item(nkps_pkg::CMD_EMIT, 0, 0, 0);
    offer_item(nkps_pkg::CMD_INSERT, 0, 0, 16'h0000);
    offer_item(nkps_pkg::CMD_INSERT, -32768, -32768, 16'hFFFF);
    offer_item(nkps_pkg::CMD_INSERT, 32767, 32767, 16'hAAAA);
    offer_item(nkps_pkg::CMD_INSERT, 3, 4, 16'h5555);
    offer_item(nkps_pkg::CMD_INSERT, 4, 3, 16'h0F0F);
    offer_item(nkps_pkg::CMD_EMIT, 0, 0, 0);
    // Full table: displace the two farthest, drop a point that only ties the
    // farthest, then displace the lowest slot among equally far entries.
    offer_item(nkps_pkg::CMD_INSERT, -4, 3, 16'hF0F0);
    offer_item(nkps_pkg::CMD_INSERT, 0, -5, 16'h1234);
    offer_item(nkps_pkg::CMD_INSERT, 5, 0, 16'h4321);
    offer_item(nkps_pkg::CMD_INSERT, 1, 0, 16'h00FF);
    offer_item(CMD_UNUSED, -1, -1, 16'hFFFF);
    offer_item(nkps_pkg::CMD_EMIT, 0, 0, 0);
    offer_item(nkps_pkg::CMD_EMIT, -1, -1, 16'hFFFF);
    offer_item(nkps_pkg::CMD_CLEAR, -1, -1, 16'hFFFF);
    offer_item(nkps_pkg::CMD_EMIT, 0, 0, 0);
    // Corner centers: largest possible distance and a point on the center.
    set_center(16'h8000, 16'h7FFF, 1'b1);
    offer_item(nkps_pkg::CMD_INSERT, 32767, -32768, 16'hFFFF);
    offer_item(nkps_pkg::CMD_INSERT, -32768, 32767, 16'h0001);
    offer_item(nkps_pkg::CMD_EMIT, 0, 0, 0);
    set_center(16'h7FFF, 16'h8000, 1'b0);
    offer_item(nkps_pkg::CMD_CLEAR, 0, 0, 0);
    offer_item(nkps_pkg::CMD_INSERT, -32768, 32767, 16'h8000);
    offer_item(nkps_pkg::CMD_INSERT, 32767, -32768, 16'h7FFF);
    offer_item(nkps_pkg::CMD_EMIT, 0, 0, 0);
  endtask

  // Scenes: optional center move, usually a clear, a run of inserts, an emit,
  // sometimes a few more inserts and a second emit.
  task automatic run_random();
    int n_pts;
    while (items_sent < ITEM_TARGET) begin
      steady_run = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 7) == 0)
        set_center(pick_center(), pick_center(), $urandom_range(0, 3) == 0);
      if ($urandom_range(0, 2) != 0)
        offer_item(nkps_pkg::CMD_CLEAR, 16'($urandom), 16'($urandom), 16'($urandom));
      n_pts = $urandom_range(0, 12);
      repeat (n_pts) begin
        if ($urandom_range(0, 19) == 0)
          offer_item(CMD_UNUSED, 16'($urandom), 16'($urandom), 16'($urandom));
        offer_item(nkps_pkg::CMD_INSERT, pick_coord(cur_cx), pick_coord(cur_cy),
                   16'($urandom));
      end
      offer_item(nkps_pkg::CMD_EMIT, 16'($urandom), 16'($urandom), 16'($urandom));
      if ($urandom_range(0, 2) == 0) begin
        repeat ($urandom_range(1, 4))
          offer_item(nkps_pkg::CMD_INSERT, pick_coord(cur_cx), pick_coord(cur_cy),
                     16'($urandom));
        offer_item(nkps_pkg::CMD_EMIT, 16'($urandom), 16'($urandom), 16'($urandom));
      end
      if ($urandom_range(0, 5) == 0) settle_block();
    end
  endtask

  // Stimulus and verdict.
  initial begin
    cur_cx = '0;
    cur_cy = '0;
    rst_n            <= 1'b0;
    in_chan.valid    <= 1'b0;
    in_chan.command  <= nkps_pkg::CMD_CLEAR;
    in_chan.pos_x    <= '0;
    in_chan.pos_y    <= '0;
    in_chan.color    <= '0;
    cfg_chan.valid   <= 1'b0;
    cfg_chan.index   <= nkps_pkg::REG_CENTER_X;
    cfg_chan.data    <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    run_directed();
    run_random();
    settle_block();
    $display("Run covered %0d inserts, %0d emits, %0d clears, %0d ignored commands, %0d writes.",
             n_insert, n_emit, n_clear, n_ignored, n_cfg);
    $display("Checked %0d result items against the predicted nearest-first order.",
             results_checked);
    if (mismatch_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

>>> sim.f
sv/nkps_pkg.sv
sv/nkps_ifs.sv
sv/nkps_cell.sv
sv/nearest_k_point_selector.sv
test/nearest_k_point_selector_checker.sv
test/nearest_k_point_selector_tb.sv
